// File: hdl/huff_pkg.sv
// Package: sizes and sequencer states for the Huffman code builder.
`default_nettype none
package huff_pkg;
  localparam int MAX_SYMBOLS = 64;
  localparam int NODES = 2 * MAX_SYMBOLS - 1;
  localparam int IDX_W = $clog2(NODES + 1);
  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int WGT_W = 22;
  localparam int IN_W = 16;
  localparam int SYM_W = 6;
  localparam int CODE_W = 63;
  localparam int LEN_W = 6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MRG_A,
    S_MRG_B,
    S_MRG_C,
    S_WALK,
    S_PAR,
    S_LEFT
  } state_t;
endpackage
`default_nettype wire

// File: hdl/huffman_code_builder_top.sv
// Top level: weight loading, tree build sequencer and code emission.
//
//   channel   signals                                         handshake
//   input     weight, last                                    start && !busy
//   result    symbol, code_bits, code_length, final_res,      valid, one cycle
//             overflow
//
// A last transaction with n leaves builds the tree in n-1 merges, each two scans of k
// node weights through the one weight RAM read port followed by the merge states
// MRG_A, MRG_B and MRG_C. Emission walks each leaf to the root one level at a time
// (parent read, left-child read, update), then issues the code for that leaf.
// Reset is synchronous and clears the leaf count, the drop flag and the sequencer;
// the node RAMs need no clearing.
// Results cannot be stalled; busy stays high until the final result is issued.
`default_nettype none
module huffman_code_builder_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [huff_pkg::IN_W-1:0]    weight,
  input  wire logic                         last,
  output logic                              valid,
  output logic      [huff_pkg::SYM_W-1:0]   symbol,
  output logic      [huff_pkg::CODE_W-1:0]  code_bits,
  output logic      [huff_pkg::LEN_W-1:0]   code_length,
  output logic                              final_res,
  output logic                              overflow
);
  localparam int IW = huff_pkg::IDX_W;
  localparam int WW = huff_pkg::WGT_W;

  huff_pkg::state_t state, state_next;

  logic [huff_pkg::CNT_W-1:0] cnt;
  logic                       drop;
  logic [IW-1:0]              k;
  logic [IW-1:0]              scan_i;
  logic                       pv;
  logic [IW-1:0]              pidx;
  logic                       pass;
  logic                       have;
  logic [IW-1:0]              best;
  logic [IW-1:0]              sub;
  logic [WW-1:0]              bw;
  logic [WW-1:0]              sw;
  logic [IW-1:0]              leaf;
  logic [IW-1:0]              pos;
  logic [IW-1:0]              par;
  logic [huff_pkg::CODE_W-1:0] bits;
  logic [huff_pkg::LEN_W-1:0] depth;

  logic                       accept;
  logic                       room;
  logic [huff_pkg::CNT_W-1:0] n_new;
  logic [IW:0]                two_n;
  logic [IW-1:0]              root;
  logic                       merges_done;
  logic                       scan_end;
  logic                       take;
  logic [WW-1:0]              cmp_ref;

  // weight RAM word: {merged flag, weight}
  logic          w_we;
  logic [IW-1:0] w_waddr;
  logic [WW:0]   w_wdata;
  logic [IW-1:0] w_raddr;
  logic [WW:0]   w_rdata;
  logic          p_we;
  logic [IW-1:0] p_waddr;
  logic [IW-1:0] p_raddr;
  logic [IW-1:0] p_rdata;
  logic          l_we;
  logic [IW-1:0] l_raddr;
  logic [IW-1:0] l_rdata;

  huff_ram #(.WIDTH(WW + 1), .DEPTH(huff_pkg::NODES)) u_wgt (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  huff_ram #(.WIDTH(IW), .DEPTH(huff_pkg::NODES)) u_par (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(k),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  huff_ram #(.WIDTH(IW), .DEPTH(huff_pkg::NODES)) u_left (
    .clk(clk), .we(l_we), .waddr(k), .wdata(best),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  huff_cmp u_cmp (
    .cand_ok(pv && !w_rdata[WW] && !(pass && pidx == best)),
    .have(have),
    .strict(pass),
    .w(w_rdata[WW-1:0]),
    .ref_w(cmp_ref),
    .take(take)
  );

  always_comb begin
    busy = state != huff_pkg::S_IDLE;
    accept = start && !busy;
    room = cnt < huff_pkg::CNT_W'(huff_pkg::MAX_SYMBOLS);
    n_new = room ? cnt + huff_pkg::CNT_W'(1) : cnt;
    two_n = {IW'(cnt), 1'b0};
    root = IW'(two_n - (IW+1)'(2));
    merges_done = ({1'b0, k} + (IW+1)'(1)) == (two_n - (IW+1)'(1));
    scan_end = pv && (pidx == k - IW'(1));
    cmp_ref = pass ? sw : bw;

    state_next = state;
    w_we = 1'b0;
    w_waddr = IW'(cnt);
    w_wdata = {1'b0, WW'(weight)};
    w_raddr = scan_i;
    p_we = 1'b0;
    p_waddr = best;
    p_raddr = pos;
    l_we = 1'b0;
    l_raddr = p_rdata;

    case (state)
      huff_pkg::S_IDLE: begin
        if (accept) begin
          w_we = room;
          if (last) begin
            state_next = (n_new == huff_pkg::CNT_W'(1)) ? huff_pkg::S_WALK : huff_pkg::S_SCAN;
          end
        end
      end
      huff_pkg::S_SCAN: begin
        if (scan_end && pass) begin
          state_next = huff_pkg::S_MRG_A;
        end
      end
      huff_pkg::S_MRG_A: begin
        w_we = 1'b1;
        w_waddr = k;
        w_wdata = {1'b0, WW'(bw + sw)};
        p_we = 1'b1;
        l_we = 1'b1;
        state_next = huff_pkg::S_MRG_B;
      end
      huff_pkg::S_MRG_B: begin
        w_we = 1'b1;
        w_waddr = best;
        w_wdata = {1'b1, bw};
        p_we = 1'b1;
        p_waddr = sub;
        state_next = huff_pkg::S_MRG_C;
      end
      huff_pkg::S_MRG_C: begin
        w_we = 1'b1;
        w_waddr = sub;
        w_wdata = {1'b1, sw};
        state_next = merges_done ? huff_pkg::S_WALK : huff_pkg::S_SCAN;
      end
      huff_pkg::S_WALK: begin
        if (pos == root) begin
          if (leaf == IW'(cnt) - IW'(1)) begin
            state_next = huff_pkg::S_IDLE;
          end
        end else begin
          state_next = huff_pkg::S_PAR;
        end
      end
      huff_pkg::S_PAR: begin
        state_next = huff_pkg::S_LEFT;
      end
      huff_pkg::S_LEFT: begin
        state_next = huff_pkg::S_WALK;
      end
      default: begin
        state_next = huff_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= huff_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      drop <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        huff_pkg::S_IDLE: begin
          if (accept) begin
            cnt <= n_new;
            if (!room) begin
              drop <= 1'b1;
            end
            if (last) begin
              k <= IW'(n_new);
              scan_i <= '0;
              pv <= 1'b0;
              pass <= 1'b0;
              have <= 1'b0;
              leaf <= '0;
              pos <= '0;
              bits <= '0;
              depth <= '0;
            end
          end
        end
        huff_pkg::S_SCAN: begin
          pv <= scan_i < k;
          pidx <= scan_i;
          scan_i <= scan_i + IW'(1);
          if (take) begin
            have <= 1'b1;
            if (pass) begin
              sw <= w_rdata[WW-1:0];
              sub <= pidx;
            end else begin
              bw <= w_rdata[WW-1:0];
              best <= pidx;
            end
          end
          if (scan_end) begin
            scan_i <= '0;
            pv <= 1'b0;
            have <= 1'b0;
            pass <= !pass;
          end
        end
        huff_pkg::S_MRG_C: begin
          k <= k + IW'(1);
        end
        huff_pkg::S_WALK: begin
          if (pos == root) begin
            valid <= 1'b1;
            symbol <= huff_pkg::SYM_W'(leaf);
            code_bits <= bits;
            code_length <= depth;
            final_res <= leaf == IW'(cnt) - IW'(1);
            overflow <= drop;
            if (leaf == IW'(cnt) - IW'(1)) begin
              cnt <= '0;
              drop <= 1'b0;
            end
            leaf <= leaf + IW'(1);
            pos <= leaf + IW'(1);
            bits <= '0;
            depth <= '0;
          end
        end
        huff_pkg::S_PAR: begin
          par <= p_rdata;
        end
        huff_pkg::S_LEFT: begin
          if (l_rdata != pos) begin
            bits <= bits | (huff_pkg::CODE_W'(1) << depth);
          end
          depth <= depth + huff_pkg::LEN_W'(1);
          pos <= par;
        end
        default: begin
        end
      endcase
    end
  end

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> busy)
    else $error("last transaction did not start a build");
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && final_res) |-> !busy)
    else $error("busy after final result");
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (valid && !final_res) |-> busy)
    else $error("idle before final result");
  a_code_clean: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((code_bits >> code_length) == '0))
    else $error("code bits above code length");
endmodule
`default_nettype wire

// File: hdl/huff_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module huff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/huff_cmp.sv
// Shared weight comparator used by both minimum-search passes.
`default_nettype none
module huff_cmp (
  input  wire logic                      cand_ok,
  input  wire logic                      have,
  input  wire logic                      strict,
  input  wire logic [huff_pkg::WGT_W-1:0] w,
  input  wire logic [huff_pkg::WGT_W-1:0] ref_w,
  output logic                           take
);
  logic lt;
  logic eq;

  always_comb begin
    lt = w < ref_w;
    eq = w == ref_w;
    take = cand_ok && (!have || lt || (!strict && eq));
  end
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Testbench for huffman_code_builder_top: weight sets in, predicted leaf codes checked out.
`timescale 1ns / 100ps
module tb_top;
  localparam int NONE = 127;
  localparam int WATCHDOG = 400000;

  typedef struct {
    logic [huff_pkg::SYM_W-1:0]  sym;
    logic [huff_pkg::CODE_W-1:0] bits;
    logic [huff_pkg::LEN_W-1:0]  len;
    logic                        fin;
    logic                        ovf;
  } code_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [huff_pkg::IN_W-1:0] weight = '0;
  logic last = 0;
  logic busy, valid, final_res, overflow;
  logic [huff_pkg::SYM_W-1:0] symbol;
  logic [huff_pkg::CODE_W-1:0] code_bits;
  logic [huff_pkg::LEN_W-1:0] code_length;

  huffman_code_builder_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .weight(weight), .last(last),
    .valid(valid), .symbol(symbol), .code_bits(code_bits), .code_length(code_length),
    .final_res(final_res), .overflow(overflow)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  code_t codes_q[$];
  int fails = 0;
  int idle_pct = 0;
  int stall_cnt = 0;

  // builder state copy
  logic [huff_pkg::WGT_W-1:0] nw[huff_pkg::NODES];
  int np[huff_pkg::NODES];
  int nl[huff_pkg::NODES];
  int nr[huff_pkg::NODES];
  int leaves = 0;
  bit dropped = 0;

  task automatic build_codes();
    int a, b, depth, pos, p;
    bit have;
    logic [huff_pkg::WGT_W-1:0] bw, sw;
    code_t c;
    for (int i = 0; i < 2 * leaves - 1; i++) begin
      np[i] = NONE;
      nl[i] = NONE;
      nr[i] = NONE;
    end
    for (int k = leaves; k < 2 * leaves - 1; k++) begin
      have = 0; a = 0; b = 0; bw = 0; sw = 0;
      for (int i = 0; i < k; i++)
        if (np[i] == NONE && (!have || nw[i] <= bw)) begin
          bw = nw[i]; a = i; have = 1;
        end
      have = 0;
      for (int i = 0; i < k; i++)
        if (np[i] == NONE && i != a && (!have || nw[i] < sw)) begin
          sw = nw[i]; b = i; have = 1;
        end
      nw[k] = nw[a] + nw[b];
      np[a] = k;
      np[b] = k;
      nl[k] = a;
      nr[k] = b;
    end
    for (int i = 0; i < leaves; i++) begin
      c.bits = '0;
      depth = 0;
      pos = i;
      p = np[i];
      while (p != NONE && depth < 63) begin
        if (nl[p] != pos) c.bits[depth] = 1'b1;
        depth++;
        pos = p;
        p = np[p];
      end
      c.sym = i[huff_pkg::SYM_W-1:0];
      c.len = depth[huff_pkg::LEN_W-1:0];
      c.fin = (i + 1 == leaves);
      c.ovf = dropped;
      codes_q.push_back(c);
    end
    leaves = 0;
    dropped = 0;
  endtask

  task automatic send(input logic [huff_pkg::IN_W-1:0] w, input logic l);
    if ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1;
    weight <= w;
    last <= l;
    @(posedge clk);
    if (leaves < huff_pkg::MAX_SYMBOLS) begin
      nw[leaves] = {6'd0, w};
      leaves++;
    end else begin
      dropped = 1;
    end
    if (l) build_codes();
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    wait (codes_q.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic [huff_pkg::IN_W-1:0] rand_weight();
    case ($urandom_range(3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 65535));
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_set(input int n);
    for (int i = 0; i < n; i++) send(rand_weight(), i == n - 1);
  endtask

  task automatic test_directed();
    send(16'h0000, 1);
    send(16'hFFFF, 1);
    send(16'd5, 0); send(16'd5, 1);
    send(16'd0, 0); send(16'hFFFF, 0); send(16'd0, 1);
    for (int i = 0; i < 4; i++) send(16'hFFFF, i == 3);
    for (int i = 0; i < 5; i++) send(16'd1, i == 4);
    send(16'd1, 0); send(16'd2, 0); send(16'd4, 0); send(16'd8, 0); send(16'd16, 1);
    drain();
  endtask

  task automatic test_overflow();
    send_set(huff_pkg::MAX_SYMBOLS + 2);
    drain();
  endtask

  task automatic test_random_sets(input int items);
    int n, sent;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(1, 10);
      send_set(n);
      sent += n;
      if ($urandom_range(7) == 0) drain();
    end
    drain();
  endtask

  always @(posedge clk) begin
    code_t e;
    if (!rst && valid) begin
      if (codes_q.size() == 0) begin
        $display("%0t: unexpected code for symbol %0d", $time, symbol);
        fails++;
      end else begin
        e = codes_q.pop_front();
        if (symbol !== e.sym || code_bits !== e.bits || code_length !== e.len ||
            final_res !== e.fin || overflow !== e.ovf) begin
          $display("%0t: exp sym %0d bits %h len %0d fin %b ovf %b", $time,
                   e.sym, e.bits, e.len, e.fin, e.ovf);
          $display("%0t: got sym %0d bits %h len %0d fin %b ovf %b", $time,
                   symbol, code_bits, code_length, final_res, overflow);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || valid || (start && !busy)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    idle_pct = 24;
    test_directed();
    test_random_sets(7);
    idle_pct = 67;
    test_overflow();
    test_random_sets(7);
    idle_pct = 0;
    test_random_sets(7);
    drain();
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
